// File: rtl/tracked_emitter_table_unit_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef TRACKED_EMITTER_TABLE_UNIT_MACROS_SVH
`define TRACKED_EMITTER_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define TETU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tetu assertion failed");

// next-cycle implication
`define TETU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tetu assertion failed");

`endif

// File: rtl/tetu_pkg.sv
// types, constants and controller/datapath command structs for the emitter table
// no dependencies
package tetu_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ID_W  = 20 * 8;
    localparam int MAC_W = 6 * 8;
    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

    typedef enum logic [1:0] {
        OP_INGEST = 2'd0,
        OP_TICK   = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        OUTC_MATCH = 2'd0,
        OUTC_FREE  = 2'd1,
        OUTC_EVICT = 2'd2,
        OUTC_NONE  = 2'd3
    } t_outcome;

    typedef struct packed {
        t_op                operation;
        logic [MAC_W-1:0]   mac;
        logic               id_present;
        logic [63:0]        id_bytes_hi;
        logic [63:0]        id_bytes_mid;
        logic [31:0]        id_bytes_lo;
        logic               mac_first;
        logic signed [7:0]  rssi;
        logic [31:0]        now_ms;
        logic [3:0]         rank;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [3:0]         slot;
        t_outcome           outcome;
        logic [MAC_W-1:0]   entry_mac;
        logic signed [7:0]  entry_rssi_best;
        logic signed [7:0]  entry_rssi_last;
        logic [31:0]        entry_packets;
        logic [4:0]         active_count;
        logic [4:0]         expired_count;
    } t_out_item;

    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [ID_W-1:0]    id;
        logic signed [7:0]  last;
        logic [31:0]        packets;
        logic [31:0]        seen;
    } t_slot_word;

    localparam int WORD_W = $bits(t_slot_word);

    typedef struct packed {
        logic               load;
        logic               walk_en;
        logic [IDX_W-1:0]   walk_idx;
        logic               fetch;
        logic               apply;
        logic               out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic               out_free;
    } t_dp_sts;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_WALK  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_APPLY = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

endpackage

// File: rtl/tetu_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tetu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tetu_ctrl.sv
// sequencing state machine: accept, slot walk, drain, fetch, update, result
// depends on tetu_pkg
module tetu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tetu_pkg::t_op     i_op,
    output logic              o_in_stall,
    output tetu_pkg::t_dp_cmd o_cmd,
    input  tetu_pkg::t_dp_sts i_sts
);
    import tetu_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = (i_op == OP_NOP) ? ST_OUT : ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.walk_en  = 1'b1;
                o_cmd.walk_idx = r_cnt;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == IDX_W'(SLOTS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FETCH;
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_APPLY;
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// File: rtl/tetu_dp.sv
// datapath: slot ram, active and best-signal registers, walk evaluation, result register
// depends on tetu_pkg and tetu_ram
module tetu_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tetu_pkg::t_in_item i_in_item,
    input  tetu_pkg::t_dp_cmd  i_cmd,
    output tetu_pkg::t_dp_sts  o_sts,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tetu_pkg::t_out_item o_out_item
);
    import tetu_pkg::*;

    logic [31:0]        r_timeout;
    t_in_item           r_item;
    logic [SLOTS-1:0]   r_active;
    logic signed [7:0]  r_best [SLOTS];

    logic               r_evld;
    logic [IDX_W-1:0]   r_eidx;
    logic               r_mac_hit, r_id_hit, r_free_hit, r_rhit;
    logic [IDX_W-1:0]   r_mac_idx, r_id_idx, r_free_idx, r_min_idx, r_ridx;
    logic signed [7:0]  r_min_val;
    logic [CNT_W-1:0]   r_drop;

    logic [IDX_W-1:0]   r_tgt;
    logic               r_matched;
    t_outcome           r_outc;
    t_out_item          r_res;
    logic               r_ovalid;
    t_out_item          r_oitem;

    logic [WORD_W-1:0]  ram_rbits;
    t_slot_word         rd;
    t_slot_word         wword;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;

    logic               idkey;
    logic [ID_W-1:0]    key;
    logic [IDX_W-1:0]   best_idx;
    logic signed [7:0]  best_cur;
    logic [CNT_W-1:0]   pos;
    logic [31:0]        age;
    logic               expire, mac_eq, id_eq;
    logic [IDX_W-1:0]   tgt_c;
    logic               matched_c;
    t_outcome           outc_c;
    logic [31:0]        cnt_base, cnt_new;
    logic signed [7:0]  best_new;
    logic [ID_W-1:0]    id_new;
    logic [CNT_W-1:0]   act_cnt;
    logic               is_ingest;
    t_out_item          blank_res;
    t_out_item          res_out;

    tetu_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tgt),
        .i_wdata (wword),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign rd        = t_slot_word'(ram_rbits);
    assign is_ingest = (r_item.operation == OP_INGEST);
    assign key       = {r_item.id_bytes_hi, r_item.id_bytes_mid, r_item.id_bytes_lo};
    assign idkey     = r_item.id_present && (|key);
    assign best_idx  = r_evld ? r_eidx : r_tgt;
    assign best_cur  = r_best[best_idx];
    assign age       = r_item.now_ms - rd.seen;
    assign expire    = r_active[r_eidx] && (age > r_timeout);
    assign mac_eq    = r_active[r_eidx] && (rd.mac == r_item.mac);
    assign id_eq     = idkey && r_active[r_eidx] && (rd.id == key);

    // rank of the walked slot among active entries
    always_comb begin
        pos = '0;
        for (int t = 0; t < SLOTS; t++) begin
            if (r_active[t] && IDX_W'(t) != r_eidx &&
                (r_best[t] > best_cur || (r_best[t] == best_cur && IDX_W'(t) < r_eidx))) begin
                pos = pos + 1'b1;
            end
        end
    end

    always_comb begin
        act_cnt = '0;
        for (int t = 0; t < SLOTS; t++) begin
            act_cnt = act_cnt + CNT_W'(r_active[t]);
        end
    end

    // empty result and result with the active count
    always_comb begin
        blank_res         = '0;
        blank_res.outcome = OUTC_NONE;
        res_out              = r_res;
        res_out.active_count = 5'(act_cnt);
    end

    // target slot selection after the walk
    always_comb begin
        tgt_c     = r_ridx;
        matched_c = 1'b0;
        outc_c    = OUTC_NONE;
        if (is_ingest) begin
            if (r_item.mac_first) begin
                if (r_mac_hit) begin
                    tgt_c = r_mac_idx; matched_c = 1'b1;
                end else if (r_id_hit) begin
                    tgt_c = r_id_idx;  matched_c = 1'b1;
                end
            end else begin
                if (r_id_hit) begin
                    tgt_c = r_id_idx;  matched_c = 1'b1;
                end else if (r_mac_hit) begin
                    tgt_c = r_mac_idx; matched_c = 1'b1;
                end
            end
            if (matched_c) begin
                outc_c = OUTC_MATCH;
            end else if (r_free_hit) begin
                tgt_c  = r_free_idx;
                outc_c = OUTC_FREE;
            end else begin
                tgt_c  = r_min_idx;
                outc_c = OUTC_EVICT;
            end
        end
    end

    assign ram_raddr = i_cmd.walk_en ? i_cmd.walk_idx : (i_cmd.fetch ? tgt_c : r_tgt);

    // new entry contents
    always_comb begin
        cnt_base = r_matched ? rd.packets : 32'd0;
        cnt_new  = (cnt_base == 32'hFFFF_FFFF) ? cnt_base : cnt_base + 32'd1;
        if (!r_matched) begin
            best_new = r_item.rssi;
        end else begin
            best_new = (r_item.rssi > best_cur) ? r_item.rssi : best_cur;
        end
        if (r_item.mac_first || r_item.id_present) begin
            id_new = r_item.id_present ? key : '0;
        end else begin
            id_new = r_matched ? rd.id : '0;
        end
        wword.mac     = r_item.mac;
        wword.id      = id_new;
        wword.last    = r_item.rssi;
        wword.packets = cnt_new;
        wword.seen    = r_item.now_ms;
    end

    assign ram_we = i_cmd.apply && is_ingest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_active  <= '0;
            r_evld    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            r_evld <= i_cmd.walk_en;
            if (r_evld && r_item.operation == OP_TICK && expire) begin
                r_active[r_eidx] <= 1'b0;
            end
            if (ram_we) begin
                r_active[r_tgt] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eidx <= i_cmd.walk_idx;
        if (ram_we) begin
            r_best[r_tgt] <= best_new;
        end
        if (i_cmd.load) begin
            r_item     <= i_in_item;
            r_mac_hit  <= 1'b0;
            r_id_hit   <= 1'b0;
            r_free_hit <= 1'b0;
            r_rhit     <= 1'b0;
            r_ridx     <= '0;
            r_drop     <= '0;
            r_res      <= blank_res;
        end
        if (r_evld) begin
            if (mac_eq && !r_mac_hit) begin
                r_mac_hit <= 1'b1; r_mac_idx <= r_eidx;
            end
            if (id_eq && !r_id_hit) begin
                r_id_hit <= 1'b1; r_id_idx <= r_eidx;
            end
            if (!r_active[r_eidx] && !r_free_hit) begin
                r_free_hit <= 1'b1; r_free_idx <= r_eidx;
            end
            if (r_eidx == '0 || best_cur < r_min_val) begin
                r_min_idx <= r_eidx; r_min_val <= best_cur;
            end
            if (r_active[r_eidx] && 32'(pos) == 32'(r_item.rank) && !r_rhit) begin
                r_rhit <= 1'b1; r_ridx <= r_eidx;
            end
            if (r_item.operation == OP_TICK && expire) begin
                r_drop <= r_drop + 1'b1;
            end
        end
        if (i_cmd.fetch) begin
            r_tgt     <= tgt_c;
            r_matched <= matched_c;
            r_outc    <= outc_c;
        end
        if (i_cmd.apply) begin
            unique case (r_item.operation)
                OP_INGEST: begin
                    r_res.hit             <= 1'b1;
                    r_res.slot            <= 4'(r_tgt);
                    r_res.outcome         <= r_outc;
                    r_res.entry_mac       <= r_item.mac;
                    r_res.entry_rssi_best <= best_new;
                    r_res.entry_rssi_last <= r_item.rssi;
                    r_res.entry_packets   <= cnt_new;
                end
                OP_READ: begin
                    if (r_rhit) begin
                        r_res.hit             <= 1'b1;
                        r_res.slot            <= 4'(r_tgt);
                        r_res.entry_mac       <= rd.mac;
                        r_res.entry_rssi_best <= best_cur;
                        r_res.entry_rssi_last <= rd.last;
                        r_res.entry_packets   <= rd.packets;
                    end
                end
                OP_TICK: begin
                    r_res.expired_count <= 5'(r_drop);
                end
                OP_NOP: begin
                    r_res.hit <= 1'b0;
                end
                default: begin
                    r_res.hit <= 1'b0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_oitem <= res_out;
        end
    end

    assign o_sts.out_free = !r_ovalid || !i_out_stall;
    assign o_out_valid    = r_ovalid;
    assign o_out_item     = r_oitem;

endmodule

// File: rtl/tracked_emitter_table_unit.sv
// Tracked emitter table: sixteen slots matched by identity or address key, with eviction of
// the weakest entry, tick-driven expiry and ranked reads by best signal. Each ingest, tick or
// read walks every slot of the ram, which has one read port, one slot per cycle, then takes a
// drain step, a fetch and an update of the chosen slot before the result beat is registered.
// The unused operation code skips the walk, fetch and update. One item is worked on at a
// time; the next is taken once the result is in the output register, even while that beat
// still waits. timeout_ms is to be written only when idle; the block does not enforce it.
// depends on tetu_pkg, tetu_ctrl, tetu_dp, tetu_ram
module tracked_emitter_table_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tetu_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tetu_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata
);
    import tetu_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tetu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_item.operation),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    tetu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// File: rtl/tetu_checker.sv
// port-level checks for the emitter table, bound to the top level
// depends on tetu_pkg and tracked_emitter_table_unit_macros.svh
`include "tracked_emitter_table_unit_macros.svh"

module tetu_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tetu_pkg::t_out_item o_out_item
);
    import tetu_pkg::*;

    `TETU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `TETU_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_item))
    `TETU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `TETU_ASSERT_IMPLY(a_ingest_hit, i_clk, i_rst_n, o_out_valid && o_out_item.outcome != OUTC_NONE, o_out_item.hit && o_out_item.expired_count == 5'd0)
    `TETU_ASSERT_IMPLY(a_miss_blank, i_clk, i_rst_n, o_out_valid && !o_out_item.hit, o_out_item.entry_packets == 32'd0 && o_out_item.slot == 4'd0)

endmodule

bind tracked_emitter_table_unit tetu_checker u_tetu_checker (.*);

// File: bench/tb_tracked_emitter_table_unit.sv
// self-checking bench for tracked_emitter_table_unit: random ingest, tick, read and nop beats
// are predicted by a behavioral table model and compared field by field; depends on tetu_pkg
`timescale 1ns / 100ps
module tb_tracked_emitter_table_unit;
    import tetu_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_item;
    logic i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    tracked_emitter_table_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // table model
    logic [31:0] mdl_timeout;
    logic mdl_act [SLOTS];
    logic [47:0] mdl_mac [SLOTS];
    logic [159:0] mdl_id [SLOTS];
    logic signed [7:0] mdl_best [SLOTS];
    logic signed [7:0] mdl_last [SLOTS];
    logic [31:0] mdl_pkts [SLOTS];
    logic [31:0] mdl_seen [SLOTS];

    t_in_item pending_beats[$];
    t_out_item expected_beats[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit in_taken = 1'b0;
    int tx_gap = 0;
    int rx_gap = 0;
    int hold_cnt = 0;
    // recent keys so that matches actually happen
    logic [47:0] mac_pool [8];
    logic [159:0] id_pool [8];

    function automatic t_out_item model_entry(t_out_item r, int s);
        r.slot = s[3:0];
        r.entry_mac = mdl_mac[s];
        r.entry_rssi_best = mdl_best[s];
        r.entry_rssi_last = mdl_last[s];
        r.entry_packets = mdl_pkts[s];
        return r;
    endfunction

    function automatic t_out_item predict_table(t_in_item it);
        t_out_item r;
        int s;
        int n;
        int pos;
        logic idkey;
        logic [159:0] key;
        r = '0;
        r.outcome = OUTC_NONE;
        key = {it.id_bytes_hi, it.id_bytes_mid, it.id_bytes_lo};
        if (it.operation == OP_INGEST) begin
            idkey = it.id_present && key != 0;
            s = -1;
            r.outcome = OUTC_MATCH;
            if (it.mac_first) begin
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && mdl_act[i] && mdl_mac[i] == it.mac) s = i;
                if (idkey)
                    for (int i = 0; i < SLOTS; i++)
                        if (s < 0 && mdl_act[i] && mdl_id[i] == key) s = i;
            end else begin
                if (idkey)
                    for (int i = 0; i < SLOTS; i++)
                        if (s < 0 && mdl_act[i] && mdl_id[i] == key) s = i;
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && mdl_act[i] && mdl_mac[i] == it.mac) s = i;
            end
            if (s < 0) begin
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && !mdl_act[i]) s = i;
                if (s >= 0) r.outcome = OUTC_FREE;
                else begin
                    s = 0;
                    for (int i = 1; i < SLOTS; i++)
                        if (mdl_best[i] < mdl_best[s]) s = i;
                    r.outcome = OUTC_EVICT;
                end
                mdl_id[s] = '0;
                mdl_pkts[s] = '0;
                mdl_best[s] = it.rssi;
            end
            mdl_act[s] = 1'b1;
            mdl_seen[s] = it.now_ms;
            mdl_mac[s] = it.mac;
            if (mdl_pkts[s] != 32'hFFFF_FFFF) mdl_pkts[s]++;
            mdl_last[s] = it.rssi;
            if (it.rssi > mdl_best[s]) mdl_best[s] = it.rssi;
            if (it.mac_first || it.id_present) mdl_id[s] = it.id_present ? key : '0;
            r.hit = 1'b1;
            r = model_entry(r, s);
        end else if (it.operation == OP_TICK) begin
            n = 0;
            for (int i = 0; i < SLOTS; i++)
                if (mdl_act[i] && (it.now_ms - mdl_seen[i]) > mdl_timeout) begin
                    mdl_act[i] = 1'b0;
                    n++;
                end
            r.expired_count = n[4:0];
        end else if (it.operation == OP_READ) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (mdl_act[i] && !r.hit) begin
                    pos = 0;
                    for (int t = 0; t < SLOTS; t++)
                        if (mdl_act[t] && t != i && (mdl_best[t] > mdl_best[i] ||
                            (mdl_best[t] == mdl_best[i] && t < i))) pos++;
                    if (pos == it.rank) begin
                        r.hit = 1'b1;
                        r = model_entry(r, i);
                    end
                end
            end
        end
        n = 0;
        for (int i = 0; i < SLOTS; i++) if (mdl_act[i]) n++;
        r.active_count = n[4:0];
        return r;
    endfunction

    function automatic t_in_item random_beat(logic [31:0] now);
        t_in_item it;
        int k;
        it = '0;
        k = $urandom_range(0, 99);
        it.operation = k < 70 ? OP_INGEST : k < 82 ? OP_TICK : k < 98 ? OP_READ : OP_NOP;
        it.mac = $urandom_range(0, 2) == 0 ? 48'({$urandom, $urandom}) :
                 mac_pool[$urandom_range(0, 7)];
        it.id_present = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: {it.id_bytes_hi, it.id_bytes_mid, it.id_bytes_lo} = '0;
            1: {it.id_bytes_hi, it.id_bytes_mid, it.id_bytes_lo} =
                {$urandom, $urandom, $urandom, $urandom, $urandom};
            default: {it.id_bytes_hi, it.id_bytes_mid, it.id_bytes_lo} = id_pool[$urandom_range(0, 7)];
        endcase
        it.mac_first = 1'($urandom_range(0, 1));
        it.rssi = 8'($urandom);
        it.now_ms = now;
        it.rank = 4'($urandom);
        return it;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) pending_beats.pop_front();
            if (!i_in_valid || in_taken) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    tx_gap <= $urandom_range(0, 7);
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= pending_beats[0];
                end else i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req <= 1'b0;
                hold_cnt <= 400;
                i_out_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                rx_gap <= $urandom_range(0, 7);
                i_out_stall <= 1'b1;
            end else i_out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item e;
        cycles <= cycles + 1;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_beats.push_back(predict_table(i_in_item));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                e = expected_beats.pop_front();
                if (o_out_item.hit !== e.hit) begin
                    $error("hit exp %0h got %0h", e.hit, o_out_item.hit); errors++; end
                if (o_out_item.slot !== e.slot) begin
                    $error("slot exp %0h got %0h", e.slot, o_out_item.slot); errors++; end
                if (o_out_item.outcome !== e.outcome) begin
                    $error("outcome exp %0h got %0h", e.outcome, o_out_item.outcome); errors++; end
                if (o_out_item.entry_mac !== e.entry_mac) begin
                    $error("entry_mac exp %0h got %0h", e.entry_mac, o_out_item.entry_mac);
                    errors++; end
                if (o_out_item.entry_rssi_best !== e.entry_rssi_best) begin
                    $error("entry_rssi_best exp %0d got %0d", e.entry_rssi_best,
                           o_out_item.entry_rssi_best); errors++; end
                if (o_out_item.entry_rssi_last !== e.entry_rssi_last) begin
                    $error("entry_rssi_last exp %0d got %0d", e.entry_rssi_last,
                           o_out_item.entry_rssi_last); errors++; end
                if (o_out_item.entry_packets !== e.entry_packets) begin
                    $error("entry_packets exp %0h got %0h", e.entry_packets,
                           o_out_item.entry_packets); errors++; end
                if (o_out_item.active_count !== e.active_count) begin
                    $error("active_count exp %0d got %0d", e.active_count,
                           o_out_item.active_count); errors++; end
                if (o_out_item.expired_count !== e.expired_count) begin
                    $error("expired_count exp %0d got %0d", e.expired_count,
                           o_out_item.expired_count); errors++; end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_beats.size() > 0 || i_in_valid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_timeout = v;
    endtask

    task automatic push_random(int n, logic [31:0] step_max);
        logic [31:0] now;
        t_in_item it;
        now = $urandom;
        for (int i = 0; i < n; i++) begin
            now += $urandom_range(0, step_max);
            it = random_beat(now);
            pending_beats.push_back(it);
            if ($urandom_range(0, 3) == 0) mac_pool[$urandom_range(0, 7)] = it.mac;
        end
    endtask

    initial begin
        t_in_item it;
        mdl_timeout = TIMEOUT_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            mdl_act[i] = 1'b0; mdl_mac[i] = '0; mdl_id[i] = '0; mdl_best[i] = '0;
            mdl_last[i] = '0; mdl_pkts[i] = '0; mdl_seen[i] = '0;
        end
        for (int i = 0; i < 8; i++) begin
            mac_pool[i] = 48'({$urandom, $urandom});
            id_pool[i] = {$urandom, $urandom, $urandom, $urandom, $urandom};
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: fill past capacity with extremes, reads, a tick, nop
        for (int i = 0; i < 18; i++) begin
            it = '0;
            it.operation = OP_INGEST;
            it.mac = i == 0 ? 48'hFFFF_FFFF_FFFF : 48'(i);
            it.id_present = i[0];
            {it.id_bytes_hi, it.id_bytes_mid, it.id_bytes_lo} = i == 1 ? '1 : id_pool[i % 8];
            it.mac_first = i[1];
            it.rssi = i == 2 ? 8'sd127 : i == 3 ? -8'sd128 : 8'(i);
            it.now_ms = i == 4 ? 32'hFFFF_FFFF : 32'd100;
            pending_beats.push_back(it);
        end
        it = '0; it.operation = OP_READ; it.rank = 4'd0; pending_beats.push_back(it);
        it.rank = 4'd15; pending_beats.push_back(it);
        it.operation = OP_NOP; pending_beats.push_back(it);
        it = '0; it.operation = OP_TICK; it.now_ms = 32'd40000; pending_beats.push_back(it);
        it.operation = OP_READ; pending_beats.push_back(it);
        wait_idle();
        write_timeout(32'd0);
        hold_req = 1'b1;
        push_random(250, 3);
        wait_idle();
        write_timeout(32'hFFFF_FFFF);
        push_random(300, 32'hFFFF_FFFF);
        wait_idle();
        write_timeout(32'd1);
        push_random(200, 2);
        wait_idle();
        write_timeout(32'd500);
        push_random(300, 200);
        wait_idle();
        quiet = 1'b1;
        push_random(150, 100);
        wait_idle();
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
